FILE: rtl/core/frame_aged_lru_batch_cache_unit_macros.svh
// Assertion macros for the frame aged cache unit
`ifndef FRAME_AGED_LRU_BATCH_CACHE_UNIT_MACROS_SVH
`define FRAME_AGED_LRU_BATCH_CACHE_UNIT_MACROS_SVH
// implication checked on every clock unless reset
`define FALC_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// next-cycle implication
`define FALC_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/falc_pkg.sv
// Package: types, constants and codes of the frame aged cache
`timescale 1ns / 1ps
`default_nettype none
package falc_pkg;
  localparam int CAPACITY_DEF = 64;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam logic [31:0] AGE_RESET = 32'd120;

  localparam logic [2:0] FN_BEGIN = 3'd0;
  localparam logic [2:0] FN_FIND  = 3'd1;
  localparam logic [2:0] FN_STORE = 3'd2;
  localparam logic [2:0] FN_INV_EP = 3'd3;
  localparam logic [2:0] FN_INV_ALL = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] frame_number;
    logic        full_frame;
    logic        allow_retained;
    logic [63:0] cache_key;
    logic [63:0] epoch_tag;
    logic        entry_valid;
    logic [31:0] hit_count_in;
    logic [31:0] payload_in;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] payload_out;
    logic [31:0] hit_count_out;
    logic [6:0]  removed_count;
    logic [6:0]  live_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic start;     // latch request, clear scan accumulators
    logic scan;      // examine slot at scan index
    logic scan_last; // last slot of scan
    logic write;     // perform the update step
  } cmd_t;
endpackage
`default_nettype wire

FILE: rtl/core/frame_aged_lru_batch_cache_unit.sv
// Frame aged LRU cache: each request scans all CAPACITY slots in one RAM.
// One request at a time: the next is accepted only after the result is taken.
// The scan is bounded by the single read port of the slot record memory.
// Synchronous reset clears valid bits, counters and frame, and sets max age to 120.
`timescale 1ns / 1ps
`default_nettype none
`include "frame_aged_lru_batch_cache_unit_macros.svh"
module frame_aged_lru_batch_cache_unit #(
  parameter int CAPACITY = falc_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = falc_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire falc_pkg::req_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output falc_pkg::rsp_t out_data
);
  falc_pkg::cmd_t cmd;
  logic [$clog2(CAPACITY)-1:0] scan_idx;

  falc_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .scan_idx(scan_idx)
  );

  falc_dp #(.CAPACITY(CAPACITY), .PAYLOAD_BITS(PAYLOAD_BITS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data), .req_in(in_data),
    .cmd(cmd), .scan_idx(scan_idx), .rsp(out_data)
  );

  `FALC_ASSERT_IMP(a_no_accept_busy, clk, rst, out_valid, !in_ready)
  `FALC_ASSERT_NXT(a_accept_not_ready, clk, rst, in_valid && in_ready, !in_ready && !out_valid)
  `FALC_ASSERT_IMP(a_live_bound, clk, rst, out_valid, out_data.live_count <= 7'(CAPACITY))
endmodule
`default_nettype wire

FILE: rtl/core/falc_ram.sv
// Generic RAM with one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module falc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/falc_ctrl.sv
// Controller: sequences the slot scan and the update for each request
`timescale 1ns / 1ps
`default_nettype none
module falc_ctrl #(
  parameter int CAPACITY = falc_pkg::CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output falc_pkg::cmd_t cmd,
  output logic [$clog2(CAPACITY)-1:0] scan_idx
);
  localparam int AW = $clog2(CAPACITY);
  typedef enum logic [1:0] {IDLE, PRIME, SCAN, WRITE} state_t;
  state_t state;
  logic [AW-1:0] idx;
  logic out_busy;

  assign in_ready = (state == IDLE) && !out_busy;
  assign out_valid = out_busy;
  assign scan_idx = idx;

  always_comb begin
    cmd.start = in_valid && in_ready;
    cmd.scan = (state == SCAN);
    cmd.scan_last = (state == SCAN) && (idx == AW'(CAPACITY - 1));
    cmd.write = (state == WRITE);
  end

  // one priming state: read address leads the scan index (registered RAM read)
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      idx <= '0;
      out_busy <= 1'b0;
    end else begin
      if (out_busy && out_ready) out_busy <= 1'b0;
      case (state)
        IDLE: if (in_valid && in_ready) begin
          state <= PRIME;
          idx <= '0;
        end
        PRIME: state <= SCAN;
        SCAN: begin
          if (idx == AW'(CAPACITY - 1)) state <= WRITE;
          else idx <= idx + 1'b1;
        end
        WRITE: begin
          state <= IDLE;
          out_busy <= 1'b1;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/falc_dp.sv
// Datapath: slot memories, valid bits, scan accumulators and result
`timescale 1ns / 1ps
`default_nettype none
module falc_dp #(
  parameter int CAPACITY = falc_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = falc_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire falc_pkg::req_t req_in,
  input  wire falc_pkg::cmd_t cmd,
  input  wire logic [$clog2(CAPACITY)-1:0] scan_idx,
  output falc_pkg::rsp_t rsp
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = 64 + 64 + PAYLOAD_BITS + 32 + 64 + 64;

  falc_pkg::req_t req;
  logic [31:0] max_age;
  logic [63:0] active_frame, insert_counter;
  logic [CAPACITY-1:0] valid;
  logic [CW-1:0] live;

  // slot record memory
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [MW-1:0] mem_wdata, mem_rdata;
  logic [63:0] r_key, r_ep, r_last, r_stamp;
  logic [PAYLOAD_BITS-1:0] r_pay;
  logic [31:0] r_hits;
  assign {r_key, r_ep, r_pay, r_hits, r_last, r_stamp} = mem_rdata;

  falc_ram #(.WIDTH(MW), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // read address runs one ahead during scan
  logic [AW-1:0] slot;
  assign slot = scan_idx;
  assign mem_raddr = cmd.start ? '0 : ((cmd.scan && !cmd.scan_last) ? scan_idx + 1'b1 : scan_idx);

  // scan accumulators
  logic found, free_found, best_ok;
  logic [AW-1:0] found_idx, free_idx, best_idx;
  logic [PAYLOAD_BITS-1:0] found_pay;
  logic [31:0] found_hits;
  logic [63:0] found_stamp, best_last, best_stamp;
  logic [31:0] best_hits;
  logic [CAPACITY-1:0] kill;
  logic [CW-1:0] removed;

  logic match, is_better, kill_now;
  logic [63:0] age;
  always_comb begin
    match = valid[slot] && r_key == req.cache_key && r_ep == req.epoch_tag;
    if (r_last != best_last) is_better = r_last < best_last;
    else if (r_hits != best_hits) is_better = r_hits < best_hits;
    else is_better = r_stamp < best_stamp;
    age = req.frame_number - r_last;
    kill_now = 1'b0;
    case (req.func)
      falc_pkg::FN_BEGIN:
        kill_now = (req.full_frame && !req.allow_retained) ||
                   (req.frame_number > r_last && age > {32'd0, max_age});
      falc_pkg::FN_INV_EP: kill_now = r_ep == req.epoch_tag;
      falc_pkg::FN_INV_ALL: kill_now = 1'b1;
      default: kill_now = 1'b0;
    endcase
    kill_now = kill_now && valid[slot];
  end

  // update decisions
  logic st_ins, st_evict, st_do;
  logic [AW-1:0] tgt;
  logic [31:0] inc_hits;
  always_comb begin
    st_ins = !found;
    st_evict = st_ins && live == CW'(CAPACITY) && best_ok;
    tgt = found ? found_idx : (st_evict ? best_idx : free_idx);
    st_do = req.func == falc_pkg::FN_STORE && req.entry_valid &&
            (found || st_evict || free_found);
    inc_hits = (found_hits == 32'hFFFF_FFFF) ? found_hits : found_hits + 32'd1;
    mem_we = 1'b0;
    mem_waddr = tgt;
    mem_wdata = {req.cache_key, req.epoch_tag, PAYLOAD_BITS'(req.payload_in),
                 req.hit_count_in, active_frame, found ? found_stamp : insert_counter};
    if (cmd.write) begin
      if (st_do) mem_we = 1'b1;
      else if (req.func == falc_pkg::FN_FIND && found) begin
        mem_we = 1'b1;
        mem_wdata = {req.cache_key, req.epoch_tag, found_pay, inc_hits,
                     active_frame, found_stamp};
      end
    end
  end

  logic [CW-1:0] rem_fin;
  assign rem_fin = (req.func == falc_pkg::FN_STORE) ? CW'(st_do && st_evict) : removed;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_age <= falc_pkg::AGE_RESET;
      active_frame <= '0;
      insert_counter <= '0;
      valid <= '0;
      live <= '0;
    end else begin
      if (cfg_we) max_age <= cfg_data;
      if (cmd.write) begin
        if (req.func == falc_pkg::FN_BEGIN) active_frame <= req.frame_number;
        if (st_do) begin
          valid[tgt] <= 1'b1;
          if (!found) insert_counter <= insert_counter + 64'd1;
          if (!found && !st_evict) live <= live + 1'b1;
        end else begin
          valid <= valid & ~kill;
          live <= live - removed;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req <= req_in;
      found <= 1'b0;
      free_found <= 1'b0;
      best_ok <= 1'b0;
      kill <= '0;
      removed <= '0;
    end else if (cmd.scan) begin
      if (match && !found) begin
        found <= 1'b1;
        found_idx <= slot;
        found_pay <= r_pay;
        found_hits <= r_hits;
        found_stamp <= r_stamp;
      end
      if (!valid[slot] && !free_found) begin
        free_found <= 1'b1;
        free_idx <= slot;
      end
      if (valid[slot] && (!best_ok || is_better)) begin
        best_ok <= 1'b1;
        best_idx <= slot;
        best_last <= r_last;
        best_hits <= r_hits;
        best_stamp <= r_stamp;
      end
      if (kill_now) begin
        kill[slot] <= 1'b1;
        removed <= removed + 1'b1;
      end
    end else if (cmd.write) begin
      rsp.hit <= req.func == falc_pkg::FN_FIND && found;
      rsp.payload_out <= (req.func == falc_pkg::FN_FIND && found) ? 32'(found_pay) : 32'd0;
      rsp.hit_count_out <= (req.func == falc_pkg::FN_FIND && found) ? inc_hits : 32'd0;
      rsp.removed_count <= 7'(rem_fin);
      rsp.live_count <= st_do ? 7'(live + CW'(!found && !st_evict)) : 7'(live - removed);
    end
  end
endmodule
`default_nettype wire

FILE: sim/tb_frame_aged_lru_batch_cache_unit.sv
// Testbench for the frame aged LRU cache: queued driver, monitor, scoreboard
`timescale 1ns / 1ps
`default_nettype none
module tb_frame_aged_lru_batch_cache_unit;
  localparam int SLOTS = 64;
  localparam int LAT = SLOTS + 3;
  // codes the block ignores
  localparam logic [2:0] FN_SPARE_LO = 3'd5;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  falc_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  falc_pkg::rsp_t out_data;

  frame_aged_lru_batch_cache_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // shadow table state
  logic        sh_valid [SLOTS];
  logic [63:0] sh_key [SLOTS];
  logic [63:0] sh_epoch [SLOTS];
  logic [31:0] sh_pay [SLOTS];
  logic [31:0] sh_hits [SLOTS];
  logic [63:0] sh_last [SLOTS];
  logic [63:0] sh_stamp [SLOTS];
  logic [63:0] sh_ins_ctr;
  logic [63:0] sh_frame;
  logic [31:0] sh_max_age;
  logic [63:0] sh_gen_frame = 64'd0;

  falc_pkg::req_t pending_reqs[$];
  falc_pkg::rsp_t expected_rsps[$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   accepted = 0;
  int   checked = 0;
  int   hits_seen = 0;

  // known keys and epochs so finds and stores collide
  logic [63:0] key_pool [16];
  logic [63:0] ep_pool [4];

  function automatic int live_slots();
    int n = 0;
    for (int i = 0; i < SLOTS; i++) if (sh_valid[i]) n++;
    return n;
  endfunction

  function automatic int find_slot(logic [63:0] k, logic [63:0] e);
    for (int i = 0; i < SLOTS; i++)
      if (sh_valid[i] && sh_key[i] == k && sh_epoch[i] == e) return i;
    return -1;
  endfunction

  // predict one response and update shadow table
  function automatic falc_pkg::rsp_t cache_predict(falc_pkg::req_t r);
    falc_pkg::rsp_t o = '0;
    int s, best, rem;
    logic better;
    rem = 0;
    case (r.func)
      falc_pkg::FN_BEGIN: begin
        sh_frame = r.frame_number;
        for (int i = 0; i < SLOTS; i++) begin
          if (!sh_valid[i]) continue;
          if ((r.full_frame && !r.allow_retained) ||
              (r.frame_number > sh_last[i] &&
               r.frame_number - sh_last[i] > {32'd0, sh_max_age})) begin
            sh_valid[i] = 1'b0;
            rem++;
          end
        end
      end
      falc_pkg::FN_FIND: begin
        s = find_slot(r.cache_key, r.epoch_tag);
        if (s >= 0) begin
          if (sh_hits[s] != 32'hFFFF_FFFF) sh_hits[s] = sh_hits[s] + 32'd1;
          sh_last[s] = sh_frame;
          o.hit = 1'b1;
          o.payload_out = sh_pay[s];
          o.hit_count_out = sh_hits[s];
        end
      end
      falc_pkg::FN_STORE: begin
        if (r.entry_valid) begin
          s = find_slot(r.cache_key, r.epoch_tag);
          if (s < 0) begin
            if (live_slots() >= SLOTS) begin
              best = -1;
              for (int i = 0; i < SLOTS; i++) begin
                if (!sh_valid[i]) continue;
                if (best < 0) begin
                  best = i;
                  continue;
                end
                if (sh_last[i] != sh_last[best]) better = sh_last[i] < sh_last[best];
                else if (sh_hits[i] != sh_hits[best]) better = sh_hits[i] < sh_hits[best];
                else better = sh_stamp[i] < sh_stamp[best];
                if (better) best = i;
              end
              if (best >= 0) begin
                sh_valid[best] = 1'b0;
                rem = 1;
              end
            end
            for (int i = 0; i < SLOTS; i++)
              if (!sh_valid[i]) begin
                s = i;
                break;
              end
            sh_valid[s] = 1'b1;
            sh_key[s] = r.cache_key;
            sh_epoch[s] = r.epoch_tag;
            sh_stamp[s] = sh_ins_ctr;
            sh_ins_ctr = sh_ins_ctr + 64'd1;
          end
          sh_pay[s] = r.payload_in;
          sh_hits[s] = r.hit_count_in;
          sh_last[s] = sh_frame;
        end
      end
      falc_pkg::FN_INV_EP: begin
        for (int i = 0; i < SLOTS; i++)
          if (sh_valid[i] && sh_epoch[i] == r.epoch_tag) begin
            sh_valid[i] = 1'b0;
            rem++;
          end
      end
      falc_pkg::FN_INV_ALL: begin
        for (int i = 0; i < SLOTS; i++)
          if (sh_valid[i]) begin
            sh_valid[i] = 1'b0;
            rem++;
          end
      end
      default: ;
    endcase
    o.removed_count = 7'(rem);
    o.live_count = 7'(live_slots());
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic falc_pkg::req_t random_req(int mode);
    falc_pkg::req_t r;
    int pick;
    r = '0;
    r.frame_number = rand64();
    r.full_frame = 1'($urandom_range(0, 1));
    r.allow_retained = 1'($urandom_range(0, 1));
    r.cache_key = key_pool[$urandom_range(0, 15)];
    r.epoch_tag = ep_pool[$urandom_range(0, 3)];
    r.entry_valid = ($urandom_range(0, 9) != 0);
    r.hit_count_in = ($urandom_range(0, 7) == 0) ?
                     32'hFFFF_FFFE + 32'($urandom_range(0, 1)) :
                     32'($urandom_range(0, 20));
    r.payload_in = $urandom;
    pick = $urandom_range(0, 99);
    if (mode == 1) begin
      // fill-heavy: many distinct keys to force evictions
      r.cache_key = rand64();
      r.func = (pick < 70) ? falc_pkg::FN_STORE : falc_pkg::FN_FIND;
    end else if (pick < 8) begin
      r.func = falc_pkg::FN_BEGIN;
      r.frame_number = sh_gen_frame + 64'($urandom_range(0, 200));
      if ($urandom_range(0, 19) == 0) r.frame_number = rand64();
      r.full_frame = ($urandom_range(0, 5) == 0);
    end else if (pick < 50) r.func = falc_pkg::FN_FIND;
    else if (pick < 90) r.func = falc_pkg::FN_STORE;
    else if (pick < 94) r.func = falc_pkg::FN_INV_EP;
    else if (pick < 96) r.func = falc_pkg::FN_INV_ALL;
    else if (pick < 98) begin
      r.func = falc_pkg::FN_FIND;
      r.cache_key = rand64();
      r.epoch_tag = rand64();
    end else r.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
    if (r.func == falc_pkg::FN_BEGIN) sh_gen_frame = r.frame_number;
    return r;
  endfunction

  task automatic shadow_reset();
    for (int i = 0; i < SLOTS; i++) begin
      sh_valid[i] = 1'b0;
      sh_key[i] = '0; sh_epoch[i] = '0; sh_pay[i] = '0;
      sh_hits[i] = '0; sh_last[i] = '0; sh_stamp[i] = '0;
    end
    sh_ins_ctr = '0;
    sh_frame = '0;
    sh_max_age = falc_pkg::AGE_RESET;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_rsps.insert(expected_rsps.size(), cache_predict(in_data));
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    falc_pkg::rsp_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected response %p", out_data);
          errors++;
        end else begin
          exp_r = expected_rsps.pop_front();
          checked++;
          if (exp_r.hit) hits_seen++;
          if (out_data.hit !== exp_r.hit) begin
            $error("hit exp %0d got %0d", exp_r.hit, out_data.hit); errors++;
          end
          if (out_data.payload_out !== exp_r.payload_out) begin
            $error("payload_out exp %h got %h", exp_r.payload_out, out_data.payload_out);
            errors++;
          end
          if (out_data.hit_count_out !== exp_r.hit_count_out) begin
            $error("hit_count_out exp %h got %h", exp_r.hit_count_out,
                   out_data.hit_count_out);
            errors++;
          end
          if (out_data.removed_count !== exp_r.removed_count) begin
            $error("removed_count exp %0d got %0d", exp_r.removed_count,
                   out_data.removed_count);
            errors++;
          end
          if (out_data.live_count !== exp_r.live_count) begin
            $error("live_count exp %0d got %0d", exp_r.live_count, out_data.live_count);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // sample on the falling edge so queue and handshake state are settled
  task automatic wait_drain();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(negedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic write_max_age(logic [31:0] v);
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_max_age = v;
  endtask

  task automatic push_op(logic [2:0] f, logic [63:0] k, logic [63:0] e,
                         logic [31:0] hc, logic [31:0] pl);
    falc_pkg::req_t r;
    r = '0;
    r.func = f; r.cache_key = k; r.epoch_tag = e;
    r.entry_valid = 1'b1; r.hit_count_in = hc; r.payload_in = pl;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic push_begin(logic [63:0] fr, logic full, logic allow);
    falc_pkg::req_t r;
    r = '0;
    r.func = falc_pkg::FN_BEGIN; r.frame_number = fr;
    r.full_frame = full; r.allow_retained = allow;
    pending_reqs.insert(pending_reqs.size(), r);
    sh_gen_frame = fr;
  endtask

  task automatic random_phase(int n, int idle, int stall, int mode);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) pending_reqs.insert(pending_reqs.size(), random_req(mode));
    wait_drain();
  endtask

  initial begin
    falc_pkg::req_t r;
    shadow_reset();
    for (int i = 0; i < 16; i++) key_pool[i] = rand64();
    key_pool[0] = '0; key_pool[1] = '1;
    for (int i = 0; i < 4; i++) ep_pool[i] = rand64();
    ep_pool[0] = '0; ep_pool[1] = '1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every operation, saturation, retirement, ignored codes
    push_op(falc_pkg::FN_FIND, '0, '0, 32'd0, 32'd0);
    push_op(falc_pkg::FN_STORE, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(falc_pkg::FN_FIND, '0, '0, 32'd0, 32'd0);
    push_op(falc_pkg::FN_STORE, '1, '1, 32'hFFFF_FFFE, 32'hA5A5_5A5A);
    push_op(falc_pkg::FN_FIND, '1, '1, 32'd0, 32'd0);
    push_op(falc_pkg::FN_FIND, '1, '1, 32'd0, 32'd0);
    push_op(falc_pkg::FN_STORE, '1, '1, 32'd5, 32'h1234_5678);
    r = '0; r.func = falc_pkg::FN_STORE; r.cache_key = 64'd7; r.entry_valid = 1'b0;
    pending_reqs.insert(pending_reqs.size(), r);
    push_op(falc_pkg::FN_FIND, 64'd7, '0, 32'd0, 32'd0);
    push_op(FN_SPARE_LO, '1, '1, 32'd0, 32'd0);
    push_op(FN_SPARE_HI, '0, '0, 32'd0, 32'd0);
    push_begin(64'd120, 1'b0, 1'b0);
    push_begin(64'd121, 1'b0, 1'b1);
    push_op(falc_pkg::FN_STORE, 64'd3, 64'd9, 32'd1, 32'd2);
    push_begin(64'd5, 1'b0, 1'b0);
    push_begin('1, 1'b1, 1'b1);
    push_op(falc_pkg::FN_INV_EP, '0, 64'd9, 32'd0, 32'd0);
    push_op(falc_pkg::FN_STORE, 64'd4, 64'd9, 32'd1, 32'd2);
    push_begin('1, 1'b1, 1'b0);
    push_op(falc_pkg::FN_STORE, 64'd4, 64'd9, 32'd1, 32'd2);
    push_op(falc_pkg::FN_INV_ALL, '0, '0, 32'd0, 32'd0);
    wait_drain();

    // max age zero, then fill past capacity to force evictions
    write_max_age(32'd0);
    random_phase(100, 0, 0, 1);
    // sender idles at random with an 80 percent chance per offer, receiver never stalls
    random_phase(120, 80, 0, 0);
    write_max_age(32'hFFFF_FFFF);
    random_phase(120, 0, 80, 0);
    write_max_age(32'd3);
    random_phase(120, 25, 25, 0);
    write_max_age(falc_pkg::AGE_RESET);
    random_phase(80, 25, 25, 1);
    random_phase(140, 0, 0, 0);

    $display("Covered %0d requests (%0d checked, %0d hits) over five ops, evictions,",
             accepted, checked, hits_seen);
    $display("aging at max age 0, 3, 120 and all ones, with sender and receiver stalls.");
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(64'd20 * 64'd2_000_000);
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire

FILE: frame_aged_lru_batch_cache_unit.f
+incdir+rtl/core
rtl/core/falc_pkg.sv
rtl/core/falc_ram.sv
rtl/core/falc_ctrl.sv
rtl/core/falc_dp.sv
rtl/core/frame_aged_lru_batch_cache_unit.sv
sim/tb_frame_aged_lru_batch_cache_unit.sv
